// ----- hw/rtl/tpte_pkg.sv -----
// Package: types, codes and constants shared by the timer pool modules.
`timescale 1ns / 1ps
`default_nettype none

package tpte_pkg;

    localparam int SLOTS     = 16;
    localparam int TICK_STEP = 1;
    localparam int CNT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // func codes of a command beat
    localparam logic [1:0] FUNC_REGISTER = 2'd0;
    localparam logic [1:0] FUNC_CLEAR    = 2'd1;
    localparam logic [1:0] FUNC_TICK     = 2'd2;
    // spare code: taken and dropped without any result
    localparam logic [1:0] FUNC_UNUSED   = 2'd3;

    // kind codes of a result beat
    localparam logic [2:0] KIND_REGISTERED = 3'd0;
    localparam logic [2:0] KIND_FULL       = 3'd1;
    localparam logic [2:0] KIND_CLEARED    = 3'd2;
    localparam logic [2:0] KIND_FIRED      = 3'd3;
    localparam logic [2:0] KIND_TICK_DONE  = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [30:0] limit_count;
        logic [30:0] start_count;
        logic [7:0]  handler;
        logic [31:0] tag;
        logic [31:0] target_id;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] timer_id;
        logic [7:0]  fired_handler;
        logic [31:0] fired_tag;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic        live;
        logic [31:0] id;
        logic [30:0] limit;
        logic [31:0] elapsed;
        logic [7:0]  handler;
        logic [31:0] tag;
    } entry_t;

    typedef struct packed {
        logic hit;
        logic fire;
    } head_evt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/timer_pool_tick_expire.sv -----
// Top level of the timer pool: ring of timer cells, head unit and sequencer.
//
// Usage:
//   A command beat (req) is taken at a rising edge with start high and busy
//   low. func selects register, clear or tick; func code 3 is dropped and
//   gives no result. Results appear on rsp for exactly one cycle, marked by
//   strobe; the receiver cannot stall them, so every strobed beat must be
//   captured. rsp.last marks the final beat of a command.
//
//   Timers live in a ring of SLOTS cells. Every command other than the spare
//   code rotates the ring once round, one cell per cycle, so each slot passes
//   the head unit in slot-index order. busy stays high through the rotation
//   and the closing state, and the closing beat sits on rsp in the cycle after
//   that; a new command is not taken before the previous one has closed.
//   Fired beats of a tick come out in the cycle after the slot passes the
//   head, one per cycle at most, and the done beat follows. busy drops in the
//   cycle the closing beat is strobed, so the next command may start then.
//
//   Reset clears every live bit (empty pool), the id counter and the
//   sequencer; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module timer_pool_tick_expire (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire tpte_pkg::req_t  req,
    output logic                 strobe,
    output tpte_pkg::rsp_t       rsp
);
    import tpte_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             found_reg, found_next;
    logic [31:0]      next_id_reg, next_id_next;
    req_t             cmd_reg;
    logic             strobe_reg, strobe_next;
    rsp_t             rsp_reg, rsp_next;

    logic             shift;
    logic             accept;
    entry_t           chain [SLOTS];
    entry_t           head_out;
    head_evt_t        evt;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign shift  = (state_reg == ST_SCAN);
    assign strobe = strobe_reg;
    assign rsp    = rsp_reg;

    // Ring: each cell takes from its upper neighbor; the top cell takes the
    // entry that the head unit has just worked on out of cell zero.
    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        entry_t cell_in;
        if (g == SLOTS - 1)
        begin : g_top
            assign cell_in = head_out;
        end
        else
        begin : g_mid
            assign cell_in = chain[g+1];
        end
        tpte_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .din   (cell_in),
            .dout  (chain[g])
        );
    end

    tpte_head u_head (
        .cmd     (cmd_reg),
        .found   (found_reg),
        .next_id (next_id_reg),
        .din     (chain[0]),
        .dout    (head_out),
        .evt     (evt)
    );

    // Hold the command for the whole rotation.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            next_id_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            found_reg   <= found_next;
            next_id_reg <= next_id_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        found_next   = found_reg;
        next_id_next = next_id_reg;
        strobe_next  = 1'b0;
        rsp_next     = rsp_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // the spare func code is taken and dropped without a result
                if (accept && req.func != FUNC_UNUSED)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                    found_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                found_next = found_reg | evt.hit;
                // emit a fired beat straight from the head unit
                if (evt.fire)
                begin
                    strobe_next            = 1'b1;
                    rsp_next.kind          = KIND_FIRED;
                    rsp_next.timer_id      = chain[0].id;
                    rsp_next.fired_handler = chain[0].handler;
                    rsp_next.fired_tag     = chain[0].tag;
                    rsp_next.last          = 1'b0;
                end
                if (cnt_reg == CNT_W'(SLOTS - 1))
                begin
                    state_next = ST_DONE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                // closing beat of the command
                state_next             = ST_IDLE;
                strobe_next            = 1'b1;
                rsp_next.timer_id      = '0;
                rsp_next.fired_handler = '0;
                rsp_next.fired_tag     = '0;
                rsp_next.last          = 1'b1;
                unique case (cmd_reg.func)
                    FUNC_REGISTER:
                    begin
                        if (found_reg)
                        begin
                            rsp_next.kind     = KIND_REGISTERED;
                            rsp_next.timer_id = next_id_reg;
                            next_id_next      = next_id_reg + 32'd1;
                        end
                        else
                        begin
                            rsp_next.kind = KIND_FULL;
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        rsp_next.kind     = KIND_CLEARED;
                        rsp_next.timer_id = cmd_reg.target_id;
                    end
                    default:
                    begin
                        rsp_next.kind = KIND_TICK_DONE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A closing beat only ever follows the closing state.
    a_last_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && rsp.last |-> $past(state_reg == ST_DONE))
        else $error("closing beat outside the closing state");

    // busy drops exactly when the closing beat is strobed.
    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && rsp.last)
        else $error("busy fell without a closing beat");

    // Beats that do not close a command are fired timers.
    a_mid_fired: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !rsp.last |-> rsp.kind == KIND_FIRED)
        else $error("non-closing beat is not a fired timer");

    // The rotation counter rests at zero outside a scan.
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_SCAN |-> cnt_reg == '0)
        else $error("rotation counter not at rest");

endmodule

`default_nettype wire

// ----- hw/rtl/tpte_cell.sv -----
// One timer cell of the rotating ring: holds an entry, takes its neighbor's on shift.
`timescale 1ns / 1ps
`default_nettype none

module tpte_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift,
    input  wire tpte_pkg::entry_t din,
    output tpte_pkg::entry_t     dout
);
    import tpte_pkg::*;

    logic        live_reg;
    entry_t      data_reg;

    // live bit clears at reset: the pool starts empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else if (shift)
        begin
            live_reg <= din.live;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= din;
        end
    end

    always_comb
    begin
        dout      = data_reg;
        dout.live = live_reg;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tpte_head.sv -----
// Head unit: applies the current command to the entry leaving cell zero.
`timescale 1ns / 1ps
`default_nettype none

module tpte_head (
    input  wire tpte_pkg::req_t    cmd,
    input  wire logic              found,
    input  wire logic [31:0]       next_id,
    input  wire tpte_pkg::entry_t  din,
    output tpte_pkg::entry_t       dout,
    output tpte_pkg::head_evt_t    evt
);
    import tpte_pkg::*;

    logic [32:0] sum;
    logic [31:0] elapsed_sat;

    always_comb
    begin
        sum         = {1'b0, din.elapsed} + 33'(TICK_STEP);
        elapsed_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        dout        = din;
        evt         = '0;
        unique case (cmd.func)
            FUNC_REGISTER:
            begin
                // take the first free slot on the way round
                if (!found && !din.live)
                begin
                    dout.live    = 1'b1;
                    dout.id      = next_id;
                    dout.limit   = cmd.limit_count;
                    dout.elapsed = {1'b0, cmd.start_count};
                    dout.handler = cmd.handler;
                    dout.tag     = cmd.tag;
                    evt.hit      = 1'b1;
                end
            end
            FUNC_CLEAR:
            begin
                if (!found && din.live && din.id == cmd.target_id)
                begin
                    dout.live = 1'b0;
                    evt.hit   = 1'b1;
                end
            end
            FUNC_TICK:
            begin
                if (din.live)
                begin
                    dout.elapsed = elapsed_sat;
                    if (elapsed_sat >= {1'b0, din.limit})
                    begin
                        dout.live = 1'b0;
                        evt.fire  = 1'b1;
                    end
                end
            end
            default:
            begin
                dout = din;
            end
        endcase
    end

endmodule

`default_nettype wire
